// ===== hw/rtl/wvr_pkg.sv =====
// Shared types and constants for the wavetable voice renderer.
package wvr_pkg;

    localparam int STEP_BITS     = 40;
    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_STEP_NUM     = 3'd0,
        REG_STEP_DEN     = 3'd1,
        REG_WAVE_LENGTH  = 3'd2,
        REG_LOOP_BEGIN   = 3'd3,
        REG_LOOP_LENGTH  = 3'd4,
        REG_DECAY_LENGTH = 3'd5,
        REG_AMPLITUDE    = 3'd6,
        REG_IGNORE_TAIL  = 3'd7
    } reg_index_t;

    // Which scaled count a start transaction is working on.
    typedef enum logic [1:0] {
        SCALE_TAIL  = 2'd0,
        SCALE_LOOP  = 2'd1,
        SCALE_START = 2'd2,
        SCALE_DECAY = 2'd3
    } scale_sel_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_SC_GO,
        OP_SC_WAIT,
        OP_TK_SEL,
        OP_SRC_GO,
        OP_SRC_WAIT,
        OP_RD0,
        OP_RD1,
        OP_RD2,
        OP_IP_GO,
        OP_IP_WAIT,
        OP_DC_ZERO,
        OP_DC_GO,
        OP_DC_WAIT,
        OP_AMP,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SC_GO,
        ST_SC_WAIT,
        ST_TK_SEL,
        ST_TK_GO,
        ST_TK_WAIT,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_IP_GO,
        ST_IP_WAIT,
        ST_DC_CHK,
        ST_DC_GO,
        ST_DC_WAIT,
        ST_AMP,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_phase_t;

    typedef struct packed {
        dp_op_t     op;
        scale_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic md_done;
        logic active;
        logic interp_needed;
        logic in_release;
        logic decay_over;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_num;
        logic [STEP_BITS-1:0] step_den;
        logic [16:0]          wave_length;
        logic [15:0]          loop_begin;
        logic [16:0]          loop_length;
        logic [23:0]          decay_length;
        logic [15:0]          amplitude;
        logic                 ignore_tail;
    } cfg_t;

endpackage

// ===== hw/rtl/wavetable_voice_render_unit.sv =====
// Wavetable voice: one looped, interpolated oscillator with release decay.
// A load writes the wave memory as it is accepted. A note start runs four scaling passes
// (tail, loop, start, decay) through the shared multiply/divide unit of P bits, where
// P = max(COUNT_BITS, 24) + 40. A tick runs an index pass, then optional interpolation
// and decay passes. One item is worked on at a time; a finished sample waits in the
// output register and a stalled result holds the next tick at its last step.
// Reset clears control and voice state; the wave memory holds garbage until loaded.
module wavetable_voice_render_unit
    import wvr_pkg::*;
#(
    parameter int WAVE_DEPTH = 65536,
    parameter int COUNT_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               kind,
    input  logic [15:0]              wave_address,
    input  logic signed [15:0]       wave_value,
    input  logic [23:0]              note_samples,
    input  logic [23:0]              note_on_samples,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [15:0]              sample,
    output logic                     last
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t st;
    logic       idle, item_accept, cfg_write;
    logic [2:0] reg_sel;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign reg_sel     = paddr[5:3];
    assign item_stall  = !idle;
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_num     <= STEP_BITS'(1);
            cfg_reg.step_den     <= STEP_BITS'(1);
            cfg_reg.wave_length  <= 17'd1;
            cfg_reg.loop_begin   <= '0;
            cfg_reg.loop_length  <= '0;
            cfg_reg.decay_length <= '0;
            cfg_reg.amplitude    <= '0;
            cfg_reg.ignore_tail  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_STEP_NUM:     cfg_reg.step_num     <= pwdata[STEP_BITS-1:0];
                REG_STEP_DEN:     cfg_reg.step_den     <= pwdata[STEP_BITS-1:0];
                REG_WAVE_LENGTH:  cfg_reg.wave_length  <= pwdata[16:0];
                REG_LOOP_BEGIN:   cfg_reg.loop_begin   <= pwdata[15:0];
                REG_LOOP_LENGTH:  cfg_reg.loop_length  <= pwdata[16:0];
                REG_DECAY_LENGTH: cfg_reg.decay_length <= pwdata[23:0];
                REG_AMPLITUDE:    cfg_reg.amplitude    <= pwdata[15:0];
                default:          cfg_reg.ignore_tail  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_STEP_NUM:     prdata = APB_DATA_BITS'(cfg_reg.step_num);
            REG_STEP_DEN:     prdata = APB_DATA_BITS'(cfg_reg.step_den);
            REG_WAVE_LENGTH:  prdata = APB_DATA_BITS'(cfg_reg.wave_length);
            REG_LOOP_BEGIN:   prdata = APB_DATA_BITS'(cfg_reg.loop_begin);
            REG_LOOP_LENGTH:  prdata = APB_DATA_BITS'(cfg_reg.loop_length);
            REG_DECAY_LENGTH: prdata = APB_DATA_BITS'(cfg_reg.decay_length);
            REG_AMPLITUDE:    prdata = APB_DATA_BITS'(cfg_reg.amplitude);
            default:          prdata = APB_DATA_BITS'(cfg_reg.ignore_tail);
        endcase
    end

    wvr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .kind        (kind),
        .st          (st),
        .cmd         (cmd),
        .idle        (idle)
    );

    wvr_datapath #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg_reg),
        .wave_address    (wave_address),
        .wave_value      (wave_value),
        .note_samples    (note_samples),
        .note_on_samples (note_on_samples),
        .result_stall    (result_stall),
        .st              (st),
        .result_valid    (result_valid),
        .sample          (sample),
        .last            (last)
    );

    // A sample is only written into the output register when that register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> st.out_free)
        else $error("sample emitted over an untaken result");

    // Launching the index computation is always followed by waiting for it.
    a_src_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SRC_GO |=> cmd.op == OP_SRC_WAIT)
        else $error("index computation launched without wait");

    // A tick transaction on an active voice starts the region select next cycle.
    a_tick_sel: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && kind == KIND_TICK && st.active |=> cmd.op == OP_TK_SEL)
        else $error("tick transaction not started");

endmodule

// ===== hw/rtl/wvr_muldiv.sv =====
// Shared sequential unit computing (a * b) / d and (a * b) % d, one bit per cycle.
module wvr_muldiv
    import wvr_pkg::*;
#(
    parameter int OPW = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [OPW-1:0]       a,
    input  logic [STEP_BITS-1:0] b,
    input  logic [STEP_BITS-1:0] d,
    output logic                 done,
    output logic [OPW+STEP_BITS-1:0] quotient,
    output logic [STEP_BITS-1:0] remainder
);

    localparam int PW = OPW + STEP_BITS;
    localparam int CW = $clog2(PW + 1);

    md_phase_t phase_reg, phase_next;
    logic [CW-1:0]        cnt_reg;
    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        mcand_reg;
    logic [STEP_BITS-1:0] mplier_reg;
    logic [STEP_BITS-1:0] div_reg;
    logic [STEP_BITS-1:0] rem_reg;
    logic [STEP_BITS:0]   rem_sh;
    logic                 rem_ge;

    assign rem_sh = {rem_reg, acc_reg[PW-1]};
    assign rem_ge = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MD_IDLE: if (start) phase_next = MD_MUL;
            MD_MUL:  if (cnt_reg == CW'(STEP_BITS - 1)) phase_next = MD_DIV;
            MD_DIV:  if (cnt_reg == CW'(PW - 1)) phase_next = MD_DONE;
            MD_DONE: phase_next = MD_IDLE;
            default: phase_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        done = (phase_reg == MD_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_next != phase_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= PW'(a);
                    mplier_reg <= b;
                    div_reg    <= d;
                    rem_reg    <= '0;
                end
            end
            MD_MUL:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[STEP_BITS-1:1]};
            end
            MD_DIV:
            begin
                if (rem_ge)
                    rem_reg <= STEP_BITS'(rem_sh - {1'b0, div_reg});
                else
                    rem_reg <= rem_sh[STEP_BITS-1:0];
                acc_reg <= {acc_reg[PW-2:0], rem_ge};
            end
            default:
            begin
            end
        endcase
    end

    assign quotient  = acc_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/wvr_ctrl.sv =====
// Sequencer for load, note start and sample rendering transactions.
module wvr_ctrl
    import wvr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_accept,
    input  logic [1:0] kind,
    input  dp_status_t st,
    output dp_cmd_t    cmd,
    output logic       idle
);

    ctrl_state_t state_reg, state_next;
    scale_sel_t  sel_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (kind == KIND_START)
                        state_next = ST_SC_GO;
                    else if (kind == KIND_TICK && st.active)
                        state_next = ST_TK_SEL;
                end
            end
            ST_SC_GO:   state_next = ST_SC_WAIT;
            ST_SC_WAIT:
            begin
                if (st.md_done)
                    state_next = (sel_reg == SCALE_DECAY) ? ST_IDLE : ST_SC_GO;
            end
            ST_TK_SEL:  state_next = ST_TK_GO;
            ST_TK_GO:   state_next = ST_TK_WAIT;
            ST_TK_WAIT: if (st.md_done) state_next = ST_RD0;
            ST_RD0:     state_next = ST_RD1;
            ST_RD1:     state_next = ST_RD2;
            ST_RD2:     state_next = st.interp_needed ? ST_IP_GO : ST_DC_CHK;
            ST_IP_GO:   state_next = ST_IP_WAIT;
            ST_IP_WAIT: if (st.md_done) state_next = ST_DC_CHK;
            ST_DC_CHK:  state_next = (st.in_release && !st.decay_over) ? ST_DC_GO : ST_AMP;
            ST_DC_GO:   state_next = ST_DC_WAIT;
            ST_DC_WAIT: if (st.md_done) state_next = ST_AMP;
            ST_AMP:     state_next = ST_EMIT;
            ST_EMIT:    if (st.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op  = OP_NONE;
        cmd.sel = sel_reg;
        idle    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && kind == KIND_LOAD)
                    cmd.op = OP_LOAD;
                else if (item_accept && kind == KIND_START)
                    cmd.op = OP_START;
            end
            ST_SC_GO:   cmd.op = OP_SC_GO;
            ST_SC_WAIT: cmd.op = OP_SC_WAIT;
            ST_TK_SEL:  cmd.op = OP_TK_SEL;
            ST_TK_GO:   cmd.op = OP_SRC_GO;
            ST_TK_WAIT: cmd.op = OP_SRC_WAIT;
            ST_RD0:     cmd.op = OP_RD0;
            ST_RD1:     cmd.op = OP_RD1;
            ST_RD2:     cmd.op = OP_RD2;
            ST_IP_GO:   cmd.op = OP_IP_GO;
            ST_IP_WAIT: cmd.op = OP_IP_WAIT;
            ST_DC_CHK:
            begin
                if (st.in_release && st.decay_over)
                    cmd.op = OP_DC_ZERO;
            end
            ST_DC_GO:   cmd.op = OP_DC_GO;
            ST_DC_WAIT: cmd.op = OP_DC_WAIT;
            ST_AMP:     cmd.op = OP_AMP;
            ST_EMIT:    if (st.out_free) cmd.op = OP_EMIT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SCALE_TAIL;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
                sel_reg <= SCALE_TAIL;
            else if (state_reg == ST_SC_WAIT && st.md_done)
                sel_reg <= scale_sel_t'(sel_reg + 2'd1);
        end
    end

endmodule

// ===== hw/rtl/wvr_datapath.sv =====
// Voice state, wave memory, sample arithmetic and result register.
module wvr_datapath
    import wvr_pkg::*;
#(
    parameter int WAVE_DEPTH = 65536,
    parameter int COUNT_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  cfg_t               cfg,
    input  logic [15:0]        wave_address,
    input  logic signed [15:0] wave_value,
    input  logic [23:0]        note_samples,
    input  logic [23:0]        note_on_samples,
    input  logic               result_stall,
    output dp_status_t         st,
    output logic               result_valid,
    output logic [15:0]        sample,
    output logic               last
);

    localparam int CB   = COUNT_BITS;
    localparam int AW   = $clog2(WAVE_DEPTH);
    localparam int LW   = $clog2(WAVE_DEPTH + 1);
    localparam int OPW  = (CB > 24) ? CB : 24;
    localparam int PW   = OPW + STEP_BITS;
    localparam int VW   = 18;
    localparam logic [31:0] CMAX32 = 32'((64'd1 << CB) - 64'd1);

    // Voice state.
    logic [CB-1:0] out_pos_reg, loop_cnt_reg, sls_reg, sll_reg;
    logic [CB-1:0] tail_start_reg, sd_reg, note_len_reg, rel_reg;
    logic          active_reg, result_valid_reg;

    // Working registers.
    logic [CB-1:0]          off_reg;
    logic [17:0]            base_reg;
    logic [AW-1:0]          idx_reg;
    logic [STEP_BITS-1:0]   frac_reg;
    logic signed [VW-1:0]   val_reg;
    logic signed [15:0]     w1_reg, rdata_reg;
    logic signed [32:0]     prod_reg;
    logic [15:0]            sample_reg;
    logic                   last_reg;

    logic signed [15:0] mem [WAVE_DEPTH];

    logic [STEP_BITS-1:0] num_eff, den_eff;
    logic [31:0]          wl32, len32, ns32, on32, sum32, tail32;
    logic [LW-1:0]        len;
    logic [17:0]          loop_stop;
    logic [16:0]          tail_src;
    logic [23:0]          scale_v;
    logic [CB-1:0]        ns_sat, on_sat, scale_sat, e;
    logic [CB:0]          rel_end, dd, dn, e_inc, loop_inc;

    logic                 md_start, md_done;
    logic [OPW-1:0]       md_a;
    logic [STEP_BITS-1:0] md_b, md_d, md_r;
    logic [PW-1:0]        md_q;

    logic signed [VW-1:0] diff, absdiff, absval, qv;
    logic signed [15:0]   c16, s16;
    logic signed [32:0]   shifted;
    logic [16:0]          gain;
    logic [31:0]          waddr32;
    logic [AW-1:0]        raddr;
    logic                 mem_we, out_free, is_last;

    assign num_eff  = (cfg.step_num == '0) ? STEP_BITS'(1) : cfg.step_num;
    assign den_eff  = (cfg.step_den == '0) ? STEP_BITS'(1) : cfg.step_den;
    assign wl32     = 32'(cfg.wave_length);
    assign len32    = (wl32 == 32'd0) ? 32'd1 :
                      ((wl32 > 32'(WAVE_DEPTH)) ? 32'(WAVE_DEPTH) : wl32);
    assign len      = LW'(len32);
    assign loop_stop = 18'(cfg.loop_begin) + 18'(cfg.loop_length);
    assign tail32   = (len32 > 32'(loop_stop)) ? len32 - 32'(loop_stop) : 32'd0;
    assign tail_src = 17'(tail32);

    assign ns32   = (32'(note_samples) > CMAX32) ? CMAX32 : 32'(note_samples);
    assign on32   = (32'(note_on_samples) > CMAX32) ? CMAX32 : 32'(note_on_samples);
    assign ns_sat = CB'(ns32);
    assign on_sat = (on32 > ns32) ? CB'(ns32) : CB'(on32);

    always_comb
    begin
        case (cmd.sel)
            SCALE_TAIL:  scale_v = 24'(tail_src);
            SCALE_LOOP:  scale_v = 24'(cfg.loop_length);
            SCALE_START: scale_v = 24'(cfg.loop_begin);
            default:     scale_v = cfg.decay_length;
        endcase
    end

    assign scale_sat = (md_q > PW'(CMAX32)) ? CB'(CMAX32) : CB'(md_q);

    assign e        = out_pos_reg;
    assign e_inc    = (CB+1)'(e) + (CB+1)'(1);
    assign loop_inc = (CB+1)'(loop_cnt_reg) + (CB+1)'(1);
    assign rel_end  = (CB+1)'(rel_reg) + (CB+1)'(sd_reg);
    assign dd       = (CB+1)'(sd_reg) + (CB+1)'(1);
    assign dn       = dd - (CB+1)'(e - rel_reg);
    assign is_last  = e_inc >= (CB+1)'(note_len_reg);

    assign diff    = VW'(w1_reg) - val_reg;
    assign absdiff = (diff < 0) ? -diff : diff;
    assign absval  = (val_reg < 0) ? -val_reg : val_reg;
    assign qv      = $signed({1'b0, md_q[VW-2:0]});

    // Sum of the source base and the resampled offset for the memory index.
    assign sum32 = 32'(base_reg) + 32'(md_q[LW-1:0]);

    always_comb
    begin
        md_start = 1'b0;
        md_a     = OPW'(scale_v);
        md_b     = den_eff;
        md_d     = num_eff;
        case (cmd.op)
            OP_SC_GO:  md_start = 1'b1;
            OP_SRC_GO:
            begin
                md_start = 1'b1;
                md_a     = OPW'(off_reg);
                md_b     = num_eff;
                md_d     = den_eff;
            end
            OP_IP_GO:
            begin
                md_start = 1'b1;
                md_a     = OPW'($unsigned(absdiff));
                md_b     = frac_reg;
                md_d     = den_eff;
            end
            OP_DC_GO:
            begin
                md_start = 1'b1;
                md_a     = OPW'($unsigned(absval));
                md_b     = STEP_BITS'(dn);
                md_d     = STEP_BITS'(dd);
            end
            default: md_start = 1'b0;
        endcase
    end

    wvr_muldiv #(
        .OPW (OPW)
    ) u_muldiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (md_start),
        .a         (md_a),
        .b         (md_b),
        .d         (md_d),
        .done      (md_done),
        .quotient  (md_q),
        .remainder (md_r)
    );

    // Wave memory: one write port, one registered read port.
    assign waddr32 = 32'(wave_address);
    assign mem_we  = (cmd.op == OP_LOAD) && (waddr32 < 32'(WAVE_DEPTH));
    assign raddr   = (cmd.op == OP_RD1) ? idx_reg + AW'(1) : idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr32[AW-1:0]] <= wave_value;
        rdata_reg <= mem[raddr];
    end

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        c16 = 16'(val_reg);
        if (val_reg < -VW'(32768))
            c16 = -16'sd32768;
        else if (val_reg > VW'(32767))
            c16 = 16'sd32767;
        gain = (cfg.amplitude == '0) ? 17'd32768 : 17'(cfg.amplitude);
        // Division by 32768 truncates toward zero.
        shifted = (prod_reg < 0) ? (prod_reg + 33'sd32767) >>> 15 : prod_reg >>> 15;
        s16 = 16'(shifted);
        if (shifted < -33'sd32768)
            s16 = -16'sd32768;
        else if (shifted > 33'sd32767)
            s16 = 16'sd32767;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_pos_reg      <= '0;
            loop_cnt_reg     <= '0;
            sls_reg          <= '0;
            sll_reg          <= '0;
            tail_start_reg   <= '0;
            sd_reg           <= '0;
            note_len_reg     <= '0;
            rel_reg          <= '0;
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_EMIT)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            case (cmd.op)
                OP_START:
                begin
                    note_len_reg <= ns_sat;
                    rel_reg      <= on_sat;
                    out_pos_reg  <= '0;
                    loop_cnt_reg <= '0;
                    active_reg   <= (ns_sat != '0);
                end
                OP_SC_WAIT:
                begin
                    if (md_done)
                    begin
                        case (cmd.sel)
                            SCALE_TAIL:
                            begin
                                if (cfg.ignore_tail || scale_sat > note_len_reg)
                                    tail_start_reg <= note_len_reg;
                                else
                                    tail_start_reg <= note_len_reg - scale_sat;
                            end
                            SCALE_LOOP:  sll_reg <= scale_sat;
                            SCALE_START: sls_reg <= scale_sat;
                            default:     sd_reg  <= scale_sat;
                        endcase
                    end
                end
                OP_TK_SEL:
                begin
                    if (e >= sls_reg && e < tail_start_reg)
                    begin
                        if (loop_inc >= (CB+1)'(sll_reg))
                            loop_cnt_reg <= '0;
                        else
                            loop_cnt_reg <= CB'(loop_inc);
                    end
                end
                OP_EMIT:
                begin
                    out_pos_reg <= CB'(e_inc);
                    if (is_last)
                        active_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_TK_SEL:
            begin
                if (e < sls_reg)
                begin
                    off_reg  <= e;
                    base_reg <= '0;
                end
                else if (e >= tail_start_reg)
                begin
                    off_reg  <= e - tail_start_reg;
                    base_reg <= loop_stop;
                end
                else
                begin
                    off_reg  <= loop_cnt_reg;
                    base_reg <= 18'(cfg.loop_begin);
                end
            end
            OP_SRC_WAIT:
            begin
                if (md_done)
                begin
                    frac_reg <= md_r;
                    if (md_q >= PW'(len) || sum32 >= 32'(len))
                        idx_reg <= AW'(len - LW'(1));
                    else
                        idx_reg <= AW'(sum32);
                end
            end
            OP_RD1:     val_reg <= VW'(rdata_reg);
            OP_RD2:     w1_reg  <= rdata_reg;
            OP_IP_WAIT:
            begin
                if (md_done)
                    val_reg <= (diff < 0) ? val_reg - qv : val_reg + qv;
            end
            OP_DC_ZERO: val_reg <= '0;
            OP_DC_WAIT:
            begin
                if (md_done)
                    val_reg <= (val_reg < 0) ? -qv : qv;
            end
            OP_AMP:     prod_reg <= 33'(c16) * $signed({16'd0, gain});
            OP_EMIT:
            begin
                sample_reg <= {~s16[15], s16[14:0]};
                last_reg   <= is_last;
            end
            default:
            begin
            end
        endcase
    end

    assign st.md_done       = md_done;
    assign st.active        = active_reg;
    assign st.interp_needed = (frac_reg != '0) && ((LW'(idx_reg) + LW'(1)) != len);
    assign st.in_release    = e >= rel_reg;
    assign st.decay_over    = (CB+1)'(e) >= rel_end;
    assign st.out_free      = out_free;

    assign result_valid = result_valid_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;

endmodule

// ===== dv/wvr_checker.sv =====
// Channel monitor, voice predictor and result comparison for the wavetable voice renderer.
module wvr_checker
    import wvr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     item_valid,
    input  logic                     item_stall,
    input  logic [1:0]               kind,
    input  logic [15:0]              wave_address,
    input  logic signed [15:0]       wave_value,
    input  logic [23:0]              note_samples,
    input  logic [23:0]              note_on_samples,
    input  logic                     result_valid,
    input  logic                     result_stall,
    input  logic [15:0]              sample,
    input  logic                     last,
    output int                       fail_count,
    output int                       pending
);

    localparam longint unsigned CNT_MAX = 64'hFF_FFFF;
    localparam longint unsigned DEPTH   = 65536;

    // A sample built from a never-loaded wave word is not compared; last still is.
    typedef struct {
        logic [15:0] sample;
        logic        last;
        bit          known;
    } voice_out_t;

    voice_out_t             expected_samples[$];
    logic signed [15:0]     wave_mem[0:65535];
    bit                     wave_written[0:65535];
    cfg_t                   cfg;
    longint unsigned        pos, loop_ctr, loop_start_out, loop_len_out;
    longint unsigned        tail_at, decay_out, note_len, release_at;
    bit                     voice_on;

    assign pending = expected_samples.size();

    function automatic longint unsigned num_eff();
        return (cfg.step_num == 0) ? 64'd1 : 64'(cfg.step_num);
    endfunction

    function automatic longint unsigned den_eff();
        return (cfg.step_den == 0) ? 64'd1 : 64'(cfg.step_den);
    endfunction

    function automatic longint unsigned len_eff();
        longint unsigned l;
        l = (cfg.wave_length == 0) ? 64'd1 : 64'(cfg.wave_length);
        return (l > DEPTH) ? DEPTH : l;
    endfunction

    // Source-sample count converted to output samples, saturated to the counter.
    function automatic longint unsigned to_out_count(longint unsigned v);
        longint unsigned q;
        q = (v * den_eff()) / num_eff();
        return (q > CNT_MAX) ? CNT_MAX : q;
    endfunction

    function automatic longint unsigned wave_index(longint unsigned base,
                                                   longint unsigned offset,
                                                   output longint unsigned frac);
        longint unsigned p, q;
        p = offset * num_eff();
        q = p / den_eff();
        frac = p % den_eff();
        if (q >= len_eff() || base + q >= len_eff())
            return len_eff() - 1;
        return base + q;
    endfunction

    task automatic begin_note(longint unsigned ns, longint unsigned ns_on);
        longint unsigned loop_stop, tail_src, tail_len;
        loop_stop = 64'(cfg.loop_begin) + 64'(cfg.loop_length);
        tail_src = (len_eff() > loop_stop) ? len_eff() - loop_stop : 0;
        if (ns_on > ns)
            ns_on = ns;
        tail_len = to_out_count(tail_src);
        tail_at = (cfg.ignore_tail || tail_len > ns) ? ns : ns - tail_len;
        loop_len_out = to_out_count(64'(cfg.loop_length));
        loop_start_out = to_out_count(64'(cfg.loop_begin));
        decay_out = to_out_count(64'(cfg.decay_length));
        note_len = ns;
        release_at = ns_on;
        pos = 0;
        loop_ctr = 0;
        voice_on = (ns != 0);
    endtask

    task automatic render_next(output voice_out_t r);
        longint unsigned e, frac, i;
        longint          val, diff, dd, dn;
        bit              known;
        e = pos;
        if (e < loop_start_out) begin
            i = wave_index(0, e, frac);
        end
        else if (e >= tail_at) begin
            i = wave_index(64'(cfg.loop_begin) + 64'(cfg.loop_length), e - tail_at, frac);
        end
        else begin
            i = wave_index(64'(cfg.loop_begin), loop_ctr, frac);
            loop_ctr++;
            if (loop_ctr >= loop_len_out)
                loop_ctr = 0;
        end
        val = longint'(wave_mem[i]);
        known = wave_written[i];
        if (frac != 0 && i + 1 != len_eff()) begin
            known = known && wave_written[i + 1];
            diff = longint'(wave_mem[i + 1]) - val;
            diff = (diff * longint'(frac)) / longint'(den_eff());
            val += diff;
        end
        if (e >= release_at) begin
            if (e >= release_at + decay_out) begin
                val = 0;
                known = 1;
            end
            else begin
                dd = longint'(decay_out) + 1;
                dn = dd - longint'(e - release_at);
                val = (val * dn) / dd;
            end
        end
        if (val < -32768) val = -32768;
        if (val > 32767) val = 32767;
        if (cfg.amplitude != 0) begin
            val = (val * longint'(cfg.amplitude)) / 32768;
            if (val < -32768) val = -32768;
            if (val > 32767) val = 32767;
        end
        val += 32768;
        r.sample = val[15:0];
        r.known = known;
        r.last = (e + 1 >= note_len);
        pos = (e + 1) & CNT_MAX;
        if (r.last)
            voice_on = 0;
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        voice_out_t exp_r;
        if (!rst_n) begin
            fail_count = 0;
            expected_samples.delete();
            cfg = '0;
            cfg.step_num = 1;
            cfg.step_den = 1;
            cfg.wave_length = 1;
            pos = 0; loop_ctr = 0; loop_start_out = 0; loop_len_out = 0;
            tail_at = 0; decay_out = 0; note_len = 0; release_at = 0;
            voice_on = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[5:3]))
                    REG_STEP_NUM:     cfg.step_num = pwdata[39:0];
                    REG_STEP_DEN:     cfg.step_den = pwdata[39:0];
                    REG_WAVE_LENGTH:  cfg.wave_length = pwdata[16:0];
                    REG_LOOP_BEGIN:   cfg.loop_begin = pwdata[15:0];
                    REG_LOOP_LENGTH:  cfg.loop_length = pwdata[16:0];
                    REG_DECAY_LENGTH: cfg.decay_length = pwdata[23:0];
                    REG_AMPLITUDE:    cfg.amplitude = pwdata[15:0];
                    REG_IGNORE_TAIL:  cfg.ignore_tail = pwdata[0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall) begin
                case (kind)
                    KIND_LOAD: begin
                        wave_mem[wave_address] = wave_value;
                        wave_written[wave_address] = 1;
                    end
                    KIND_START: begin_note(64'(note_samples), 64'(note_on_samples));
                    KIND_TICK: begin
                        if (voice_on) begin
                            render_next(exp_r);
                            expected_samples.push_back(exp_r);
                        end
                    end
                    default: ;
                endcase
            end
            if (result_valid && !result_stall) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %0d last %0b", sample, last));
                end
                else begin
                    exp_r = expected_samples.pop_front();
                    if (exp_r.known && sample !== exp_r.sample)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  sample, exp_r.sample));
                    if (last !== exp_r.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  last, exp_r.last));
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the wavetable voice renderer testbench: clock, reset, stimulus and verdict.
module tb_top;
    import wvr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         LIMIT_CYCLES = 20_000_000;
    localparam int         SETTLE_CYCLES = 500;

    logic                     clk;
    logic                     rst_n;
    logic                     psel, penable, pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     item_valid, item_stall;
    logic [1:0]               kind;
    logic [15:0]              wave_address;
    logic signed [15:0]       wave_value;
    logic [23:0]              note_samples, note_on_samples;
    logic                     result_valid, result_stall;
    logic [15:0]              sample;
    logic                     last;
    int                       fail_count, pending;
    int                       cycle_count;
    int                       hold_request;

    wavetable_voice_render_unit dut (.*);

    wvr_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: free-running stretches, short stalls, occasional long ones,
    // plus one forced hold-off that lets the block back up into its input.
    initial
    begin
        int run_left;
        bit run_stalled;
        int r;
        run_left = 0;
        run_stalled = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                run_left = hold_request;
                run_stalled = 1;
                hold_request = 0;
            end
            else if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    run_stalled = 0;
                    run_left = $urandom_range(1, 60);
                end
                else if (r < 90)
                begin
                    run_stalled = 1;
                    run_left = $urandom_range(1, 3);
                end
                else
                begin
                    run_stalled = 1;
                    run_left = $urandom_range(20, 300);
                end
            end
            result_stall <= run_stalled;
            run_left--;
        end
    end

    task automatic apb_write(reg_index_t idx, logic [APB_DATA_BITS-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_ADDR_BITS'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one transaction after an idle gap and returns once it is taken.
    // Valid stays high afterwards so back-to-back transactions need no toggle.
    task automatic offer(int gap, logic [1:0] k, logic [15:0] addr, logic [15:0] value,
                         logic [23:0] ns, logic [23:0] ns_on);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind <= k;
        wave_address <= addr;
        wave_value <= value;
        note_samples <= ns;
        note_on_samples <= ns_on;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Drops valid and waits until every predicted sample has come out, plus
    // time for a start transaction still in flight.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [39:0] random_step(int style);
        case (style)
            0: return 40'd1;
            1: return 40'hFF_FFFF_FFFF;
            2: return 40'd0;
            3: return {8'($urandom_range(0, 255)), $urandom};
            default: return 40'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic random_config(int phase);
        logic [16:0] wl;
        logic [39:0] num;
        case (phase % 5)
            0: wl = 17'($urandom_range(1, 64));
            1: wl = 17'd0;
            2: wl = 17'd65536;
            3: wl = 17'h1FFFF;
            default: wl = 17'($urandom_range(2, 300));
        endcase
        num = random_step(phase < 5 ? phase : $urandom_range(0, 7));
        apb_write(REG_STEP_NUM, 64'(num));
        if (phase == 6)
            apb_write(REG_STEP_DEN, 64'(num + 40'($urandom_range(1, 9))));
        else
            apb_write(REG_STEP_DEN, 64'(random_step(phase < 5 ? 4 - phase
                                                    : $urandom_range(0, 7))));
        apb_write(REG_WAVE_LENGTH, 64'(wl));
        apb_write(REG_LOOP_BEGIN, (phase == 3) ? 64'd65535
                                               : 64'($urandom_range(0, 40)));
        apb_write(REG_LOOP_LENGTH, (phase == 2) ? 64'h1FFFF
                                                : 64'($urandom_range(0, 40)));
        apb_write(REG_DECAY_LENGTH, (phase == 4) ? 64'hFF_FFFF
                                                 : 64'($urandom_range(0, 80)));
        case (phase % 3)
            0: apb_write(REG_AMPLITUDE, 64'd0);
            1: apb_write(REG_AMPLITUDE, 64'd65535);
            default: apb_write(REG_AMPLITUDE, 64'($urandom_range(1, 65535)));
        endcase
        apb_write(REG_IGNORE_TAIL, 64'(phase % 2));
    endtask

    initial
    begin
        int r;
        logic [23:0] ns;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        kind = KIND_TICK;
        wave_address = '0;
        wave_value = '0;
        note_samples = '0;
        note_on_samples = '0;
        hold_request = 0;
        cycle_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the low words that the short wave lengths reach, and the top words.
        for (int a = 0; a < 320; a++)
            offer(0, KIND_LOAD, 16'(a), 16'($urandom), '0, '0);
        for (int a = 65520; a < 65536; a++)
            offer(0, KIND_LOAD, 16'(a), 16'($urandom), '0, '0);

        // Directed part under the reset configuration.
        offer(0, KIND_LOAD, 16'hFFFF, 16'h8000, '0, '0);
        offer(0, KIND_LOAD, 16'h0000, 16'h7FFF, '0, '0);
        offer(0, KIND_TICK, '0, '0, '0, '0);
        offer(0, KIND_START, '0, '0, 24'd5, 24'd2);
        repeat (6) offer(0, KIND_TICK, '0, '0, '0, '0);
        offer(0, KIND_START, '0, '0, 24'd0, 24'd0);
        offer(0, KIND_TICK, '0, '0, '0, '0);
        offer(0, KIND_START, '0, '0, 24'hFF_FFFF, 24'hFF_FFFF);
        repeat (2) offer(0, KIND_TICK, '0, '0, '0, '0);
        // A second start mid-note restarts it, and a release beyond the end is limited.
        offer(0, KIND_START, '0, '0, 24'd3, 24'hFF_FFFF);
        offer(0, KIND_UNUSED, '0, '0, '0, '0);
        repeat (3) offer(0, KIND_TICK, '0, '0, '0, '0);

        for (int phase = 0; phase < 10; phase++)
        begin
            drain();
            random_config(phase);
            if (phase == 4)
                hold_request = 3000;
            for (int n = 0; n < 200; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    offer(random_gap(), KIND_LOAD, 16'($urandom), 16'($urandom), '0, '0);
                end
                else if (r < 18)
                begin
                    ns = ($urandom_range(0, 19) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 60));
                    offer(random_gap(), KIND_START, '0, '0, ns,
                          ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 70)));
                end
                else if (r < 19)
                begin
                    offer(random_gap(), KIND_UNUSED, 16'($urandom), 16'($urandom),
                          24'($urandom), 24'($urandom));
                end
                else
                begin
                    offer(random_gap(), KIND_TICK, 16'($urandom), 16'($urandom),
                          24'($urandom), 24'($urandom));
                end
            end
        end
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
